/* sv/sldf_pkg.sv */
package sldf_pkg;

	localparam int MAX_PAYLOAD = 28;
	localparam int LEN_W       = 5;
	localparam int IDX_W       = $clog2(MAX_PAYLOAD);
	localparam int NUM_BANKS   = 2;

	localparam logic [7:0] SYNC_A   = 8'h55;
	localparam logic [7:0] SYNC_ACK = 8'hAF;

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_ID,
		PH_LEN,
		PH_DATA,
		PH_SUM
	} phase_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FETCH,
		B_SHOW
	} bstate_t;

	// one checked frame waiting to be emitted
	typedef struct packed {
		logic [7:0]       id;
		logic             ack;
		logic [LEN_W-1:0] len;
		logic             bank;
	} desc_t;

	// payload write from the parser into the frame buffer
	typedef struct packed {
		logic             en;
		logic             bank;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
	} wr_t;

endpackage

/* sv/sldf_front.sv */
module sldf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 q_full,
	output logic                 in_ready,
	output logic                 push,
	output sldf_pkg::desc_t      push_desc,
	output sldf_pkg::wr_t        wr
);
	import sldf_pkg::*;

	phase_t           phase_q, phase_d;
	logic [7:0]       sum_q;
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       id_q;
	logic             ack_q;
	logic             bank_q;
	logic             take;
	logic [LEN_W-1:0] fill_nx;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign fill_nx  = fill_q + LEN_W'(1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			unique case (phase_q)
				PH_SYNC1: if (in_byte == SYNC_A) phase_d = PH_SYNC2;
				PH_SYNC2: begin
					if (in_byte == SYNC_A || in_byte == SYNC_ACK) phase_d = PH_ID;
					else phase_d = PH_SYNC1;
				end
				PH_ID: phase_d = PH_LEN;
				PH_LEN: begin
					if (in_byte > 8'(MAX_PAYLOAD)) phase_d = PH_SYNC1;
					else if (in_byte == 8'd0) phase_d = PH_SUM;
					else phase_d = PH_DATA;
				end
				PH_DATA: if (fill_nx >= len_q) phase_d = PH_SUM;
				PH_SUM: phase_d = PH_SYNC1;
				default: phase_d = PH_SYNC1;
			endcase
		end
	end

	// outputs toward queue and buffer
	always_comb begin
		push           = take && (phase_q == PH_SUM) && (in_byte == sum_q);
		push_desc.id   = id_q;
		push_desc.ack  = ack_q;
		push_desc.len  = len_q;
		push_desc.bank = bank_q;
		wr.en          = take && (phase_q == PH_DATA);
		wr.bank        = bank_q;
		wr.idx         = fill_q[IDX_W-1:0];
		wr.data        = in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			sum_q   <= '0;
			fill_q  <= '0;
			len_q   <= '0;
			id_q    <= '0;
			ack_q   <= 1'b0;
			bank_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (push) bank_q <= !bank_q;
			if (take) begin
				unique case (phase_q)
					PH_SYNC1: if (in_byte == SYNC_A) sum_q <= in_byte;
					PH_SYNC2: begin
						if (in_byte == SYNC_A || in_byte == SYNC_ACK) begin
							ack_q <= (in_byte == SYNC_ACK);
							sum_q <= sum_q + in_byte;
						end
					end
					PH_ID: begin
						id_q  <= in_byte;
						sum_q <= sum_q + in_byte;
					end
					PH_LEN: begin
						if (in_byte <= 8'(MAX_PAYLOAD)) begin
							len_q  <= in_byte[LEN_W-1:0];
							fill_q <= '0;
							sum_q  <= sum_q + in_byte;
						end
					end
					PH_DATA: begin
						fill_q <= fill_nx;
						sum_q  <= sum_q + in_byte;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

/* sv/sldf_queue.sv */
module sldf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sldf_pkg::desc_t push_desc,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output sldf_pkg::desc_t head
);
	import sldf_pkg::*;

	// one entry per buffer bank; an entry is released after its last result
	desc_t      ent_q [NUM_BANKS];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'(NUM_BANKS));
	assign not_empty = (cnt_q != 2'd0);
	assign head      = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/sldf_back.sv */
module sldf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sldf_pkg::wr_t             wr,
	input  logic                      q_not_empty,
	input  sldf_pkg::desc_t           head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_id,
	output logic                      out_ack,
	output logic [sldf_pkg::LEN_W-1:0] out_len,
	output logic [sldf_pkg::LEN_W-1:0] out_idx,
	output logic [7:0]                out_data,
	output logic                      out_last
);
	import sldf_pkg::*;

	logic [7:0] mem [NUM_BANKS][MAX_PAYLOAD];
	logic [7:0] rdata_q;

	bstate_t          st_q, st_d;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] idx_nx;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic             shown;
	logic             start;
	logic             start_empty;

	assign idx_nx      = idx_q + LEN_W'(1);
	assign shown       = (st_q == B_SHOW) && out_ready;
	assign start       = (st_q == B_IDLE) && q_not_empty;
	assign start_empty = start && (head.len == '0);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: begin
				if (start_empty) st_d = B_SHOW;
				else if (start) st_d = B_FETCH;
			end
			B_FETCH: st_d = B_SHOW;
			B_SHOW: begin
				if (out_ready) st_d = out_last ? B_IDLE : B_FETCH;
			end
			default: st_d = B_IDLE;
		endcase
	end

	// read port control
	always_comb begin
		out_valid = (st_q == B_SHOW);
		pop       = shown && out_last;
		rd_en     = (start && !start_empty) || (shown && !out_last);
		rd_idx    = (st_q == B_IDLE) ? '0 : idx_nx[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.bank][wr.idx] <= wr.data;
		if (rd_en) rdata_q <= mem[head.bank][rd_idx];
	end

	// result register
	always_ff @(posedge clk) begin
		if (start) begin
			out_id  <= head.id;
			out_ack <= head.ack;
			out_len <= head.len;
			out_idx <= '0;
		end
		if (start_empty) begin
			out_data <= '0;
			out_last <= 1'b1;
		end
		if (st_q == B_FETCH) begin
			out_idx  <= idx_q;
			out_data <= rdata_q;
			out_last <= (idx_nx == out_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_IDLE;
			idx_q <= '0;
		end else begin
			st_q <= st_d;
			if (start) idx_q <= '0;
			else if (shown) idx_q <= idx_nx;
		end
	end

endmodule

/* sv/sync_length_checksum_deframer_core.sv */
// Channel  Dir  Signals                     Request contents
// s_axis   in   tvalid tready tdata[7:0]    rx_byte
// m_axis   out  tvalid tready tdata[31:0]   msg_id, payload_len, byte_index, data_byte
//                      tuser[0] tlast        is_ack; last result of the frame
//
// Input: one byte per cycle while a buffer bank is free; tready drops only when
// both payload banks hold checked frames that are not yet fully drained.
// Output: each payload result passes a buffer read, then the result register, and
// the next read waits until that result is taken; an empty frame gives one result.
// Reset clears parser, queue and drain state; the payload buffer is not cleared
// and needs no clearing pass, since every emitted byte was written in its frame.
// A stalled output never blocks the parser unless both banks are occupied.
module sync_length_checksum_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] msg_id, [12:8] payload_len, [17:13] byte_index, [25:18] data_byte, rest 0
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tuser,   // [0] is_ack
	output logic        m_axis_tlast
);
	import sldf_pkg::*;

	logic             q_full;
	logic             q_not_empty;
	logic             push;
	logic             pop;
	desc_t            push_desc;
	desc_t            head;
	wr_t              wr;
	logic [7:0]       msg_id;
	logic             is_ack;
	logic [LEN_W-1:0] payload_len;
	logic [LEN_W-1:0] byte_index;
	logic [7:0]       data_byte;

	// front: sync hunt, header checks, running checksum, payload capture
	sldf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.push_desc (push_desc),
		.wr        (wr)
	);

	// checked frames waiting to drain, one per bank
	sldf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	// back: payload buffer and per-byte result run
	sldf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_id      (msg_id),
		.out_ack     (is_ack),
		.out_len     (payload_len),
		.out_idx     (byte_index),
		.out_data    (data_byte),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, data_byte, byte_index, payload_len, msg_id};
	assign m_axis_tuser = is_ack;

endmodule

/* test/sldf_frame_checker.sv */
module sldf_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] msg_id, [12:8] payload_len, [17:13] byte_index, [25:18] data_byte, rest 0
	input  logic [31:0] m_axis_tdata,
	input  logic        m_axis_tuser,   // [0] is_ack
	input  logic        m_axis_tlast,
	output int          err_count,
	output int          pending
);
	import sldf_pkg::*;

	typedef struct packed {
		logic [7:0]       msg_id;
		logic             is_ack;
		logic [LEN_W-1:0] payload_len;
		logic [LEN_W-1:0] byte_index;
		logic [7:0]       data_byte;
		logic             last;
	} beat_t;

	// shadow of the parser
	phase_t           hunt_phase;
	logic [7:0]       run_sum;
	logic [LEN_W-1:0] fill_cnt;
	logic [LEN_W-1:0] cur_len;
	logic [7:0]       cur_id;
	logic             cur_ack;
	logic [7:0]       payload_mem [MAX_PAYLOAD];

	beat_t expected_beats [$];

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// advance the shadow parser by one byte, queue the frame's results on a good checksum
	task automatic parse_byte(input logic [7:0] b);
		beat_t beat;
		case (hunt_phase)
			PH_SYNC1: begin
				if (b == SYNC_A) begin
					run_sum    = b;
					hunt_phase = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (b == SYNC_A || b == SYNC_ACK) begin
					cur_ack    = (b == SYNC_ACK);
					run_sum    = run_sum + b;
					hunt_phase = PH_ID;
				end else begin
					hunt_phase = PH_SYNC1;
				end
			end
			PH_ID: begin
				cur_id     = b;
				run_sum    = run_sum + b;
				hunt_phase = PH_LEN;
			end
			PH_LEN: begin
				if (b <= MAX_PAYLOAD) begin
					cur_len    = b[LEN_W-1:0];
					fill_cnt   = '0;
					run_sum    = run_sum + b;
					hunt_phase = (b != 8'd0) ? PH_DATA : PH_SUM;
				end else begin
					hunt_phase = PH_SYNC1;
				end
			end
			PH_DATA: begin
				payload_mem[fill_cnt] = b;
				fill_cnt = fill_cnt + 1'b1;
				run_sum  = run_sum + b;
				if (fill_cnt >= cur_len)
					hunt_phase = PH_SUM;
			end
			PH_SUM: begin
				hunt_phase = PH_SYNC1;
				if (run_sum == b) begin
					beat.msg_id      = cur_id;
					beat.is_ack      = cur_ack;
					beat.payload_len = cur_len;
					if (cur_len == '0) begin
						// empty frame: one zero beat
						beat.byte_index = '0;
						beat.data_byte  = '0;
						beat.last       = 1'b1;
						expected_beats.push_back(beat);
					end else begin
						for (int k = 0; k < cur_len; k++) begin
							beat.byte_index = LEN_W'(k);
							beat.data_byte  = payload_mem[k];
							beat.last       = (k + 1 == cur_len);
							expected_beats.push_back(beat);
						end
					end
				end
			end
			default: hunt_phase = PH_SYNC1;
		endcase
	endtask

	task automatic check_beat();
		beat_t want;
		if (expected_beats.size() == 0) begin
			$error("result with nothing expected: tdata %h tuser %b tlast %b",
				m_axis_tdata, m_axis_tuser, m_axis_tlast);
			err_count++;
		end else begin
			want = expected_beats.pop_front();
			check_field("msg_id", want.msg_id, m_axis_tdata[7:0]);
			check_field("payload_len", want.payload_len, m_axis_tdata[12:8]);
			check_field("byte_index", want.byte_index, m_axis_tdata[17:13]);
			check_field("data_byte", want.data_byte, m_axis_tdata[25:18]);
			check_field("tdata_pad", 0, m_axis_tdata[31:26]);
			check_field("is_ack", want.is_ack, m_axis_tuser);
			check_field("last", want.last, m_axis_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_phase = PH_SYNC1;
			run_sum    = '0;
			fill_cnt   = '0;
			cur_len    = '0;
			cur_id     = '0;
			cur_ack    = 1'b0;
			expected_beats.delete();
			err_count  = 0;
			pending    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_beat();
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata);
			pending = expected_beats.size();
		end
	end

endmodule

/* test/sync_length_checksum_deframer_core_tb.sv */
module sync_length_checksum_deframer_core_tb;
	import sldf_pkg::*;

	// run length: ~320 bytes with random sender gaps between bursts, plus up to 28
	// results per frame under random output stalls and one long output hold-off;
	// RUN_LIMIT stays many times over the slowest correct run
	localparam int RUN_LIMIT     = 200000;
	localparam int ITEM_TARGET   = 320;
	localparam int HOLD_CYCLES   = 400;   // long output hold-off, fills both banks
	localparam int SETTLE_CYCLES = 80;    // > one full 28-byte frame drain

	// output-side stall patterns
	typedef enum logic [1:0] {
		RX_FULL,   // always ready
		RX_COIN,   // ready half the time
		RX_MASK,   // fixed 8-bit on/off mask, random per mode
		RX_SLOW    // ready a fifth of the time, at random
	} rx_mode_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;     // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // [7:0] msg_id, [12:8] payload_len,
	                                     // [17:13] byte_index, [25:18] data_byte, rest 0
	logic        m_axis_tuser;           // [0] is_ack
	logic        m_axis_tlast;

	int err_count;
	int pending;      // results still owed by the block, from the checker

	int          items_sent = 0;   // frame bytes accepted, line noise not counted
	int          burst_left = 0;   // requests left in the current input burst
	int unsigned cycle_cnt  = 0;
	int          hold_reqs  = 0;   // long hold-offs asked by the stimulus
	int          holds_done = 0;   // long hold-offs carried out by the receiver

	sync_length_checksum_deframer_core dut (.*);

	sldf_frame_checker frame_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin : watchdog
		while (cycle_cnt < RUN_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one byte and hold it until accepted. Requests go out in bursts of
	// random length; between bursts tvalid usually drops for a random gap. tvalid is
	// never lowered and raised in the same step, so back-to-back bytes in a
	// burst keep it high.
	task automatic send_byte(input logic [7:0] b, input bit counted);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		if (counted)
			items_sent++;
	endtask

	// One frame: sync, second sync, id, length, payload, checksum. The frame is
	// cut short where the parser gives up (bad second sync, oversize length).
	// fill < 0 gives random payload bytes, otherwise every byte is fill.
	task automatic send_frame(input logic [7:0] second, input logic [7:0] id,
			input logic [7:0] len, input bit bad_sum, input int fill);
		logic [7:0] sum;
		logic [7:0] b;
		send_byte(SYNC_A, 1'b1);
		send_byte(second, 1'b1);
		if (second != SYNC_A && second != SYNC_ACK)
			return;
		send_byte(id, 1'b1);
		send_byte(len, 1'b1);
		if (len > MAX_PAYLOAD)
			return;
		sum = SYNC_A + second + id + len;
		for (int k = 0; k < len; k++) begin
			b   = (fill < 0) ? 8'($urandom) : 8'(fill);
			sum = sum + b;
			send_byte(b, 1'b1);
		end
		// a corrupted checksum differs in at least one bit
		send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum, 1'b1);
	endtask

	// Wait until every expected result has been taken. The count is read at the
	// falling edge so it is settled; returns just after a rising edge.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] second;
		logic [7:0] len;
		int         pick;
		bit         hold_asked;
		bit         paused;

		hold_asked = 1'b0;
		paused     = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		send_frame(SYNC_A, 8'h00, 8'd0, 1'b0, -1);     // empty data frame, id 0
		send_frame(SYNC_ACK, 8'hFF, 8'd0, 1'b0, -1);   // empty ack frame, id all ones
		send_frame(8'h00, 8'h00, 8'd0, 1'b0, -1);      // bad second sync byte
		send_frame(SYNC_A, 8'h80, 8'hFF, 1'b0, -1);    // length far over the limit
		send_frame(SYNC_A, 8'h01, 8'd1, 1'b1, 8'h00);  // checksum mismatch, dropped
		send_frame(SYNC_ACK, 8'h7E, 8'd2, 1'b0, 8'hFF); // ack frame with all-ones data

		// --- random part: mostly well-formed frames, some broken ones, some noise ---
		while (items_sent < ITEM_TARGET) begin
			// output holds off for a long stretch while input keeps flowing
			if (!hold_asked && items_sent >= 90) begin
				hold_reqs <= hold_reqs + 1;
				hold_asked = 1'b1;
			end
			// input pauses until the block has delivered everything owed
			if (!paused && items_sent >= 210) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
				paused = 1'b1;
			end

			second = $urandom_range(0, 2) == 0 ? SYNC_ACK : SYNC_A;
			// mostly short payloads, some at the maximum, some empty
			case ($urandom_range(0, 9))
				0:       len = 8'(MAX_PAYLOAD);
				1:       len = 8'd0;
				2:       len = 8'($urandom_range(0, MAX_PAYLOAD));
				default: len = 8'($urandom_range(1, 6));
			endcase

			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(second, 8'($urandom), len, 1'b0, -1);
			end else if (pick < 80) begin
				send_frame(second, 8'($urandom), len, 1'b1, -1);
			end else if (pick < 86) begin
				do
					second = 8'($urandom);
				while (second == SYNC_A || second == SYNC_ACK);
				send_frame(second, 8'($urandom), len, 1'b0, -1);
			end else if (pick < 92) begin
				// just over the limit or anywhere above it
				len = $urandom_range(0, 1) ? 8'(MAX_PAYLOAD + 1) :
					8'($urandom_range(MAX_PAYLOAD + 1, 255));
				send_frame(SYNC_A, 8'($urandom), len, 1'b0, -1);
			end else begin
				// line noise; may land mid-frame and shift the parse
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom), 1'b0);
			end
		end

		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Output side: own stall pattern, switched at random, plus the long
	// hold-off on request, counted here in cycles.
	// ------------------------------------------------------------------
	initial begin : receiver
		rx_mode_t   mode;
		int         mode_left;
		logic [7:0] stall_mask;
		logic [2:0] tick;

		mode       = RX_FULL;
		mode_left  = 0;
		stall_mask = '1;
		tick       = '0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				if (mode_left == 0) begin
					mode       = rx_mode_t'($urandom_range(0, 3));
					mode_left  = $urandom_range(16, 128);
					stall_mask = 8'($urandom) | 8'h01;
				end
				mode_left--;
				tick++;
				case (mode)
					RX_FULL: m_axis_tready <= 1'b1;
					RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
					RX_MASK: m_axis_tready <= stall_mask[tick];
					default: m_axis_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

endmodule

/* sync_length_checksum_deframer_core.f */
sv/sldf_pkg.sv
sv/sldf_front.sv
sv/sldf_queue.sv
sv/sldf_back.sv
sv/sync_length_checksum_deframer_core.sv
test/sldf_frame_checker.sv
test/sync_length_checksum_deframer_core_tb.sv
